// File: src/rar_pkg.sv
// rar_pkg: shared types and constants for the rational arithmetic reduce unit
// holds the sequencer state type, action codes and the fixed result width
// no dependencies

package rar_pkg;

   localparam int RESULT_BITS = 33;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GCD,
      ST_DIV_N,
      ST_DIV_D
   } state_type;

   typedef enum logic [1:0] {
      MSTEP_T1 = 2'd0,
      MSTEP_T2 = 2'd1,
      MSTEP_DEN = 2'd2
   } mstep_type;

endpackage

// File: src/rational_arith_reduce_unit.sv
// rational_arith_reduce_unit: add, subtract, multiply or divide two signed
// fractions and reduce the result by the gcd of numerator and denominator
// depends on rar_pkg
//
// - command channel: a transaction is taken at a rising edge with start high
//   and busy low; req_action selects add, subtract, multiply or divide
// - busy is high from the accepting edge until the result edge; commands
//   offered while busy are ignored
// - result channel: rsp_valid marks one cycle of rsp_result_num,
//   rsp_result_den and rsp_zero_den_error; the receiver cannot stall
// - busy drops with the rsp_valid edge, so the next command can be taken
//   while the previous result is on the ports
// - order: multiplier steps (cross terms, denominator), a combine step, the gcd
//   steps and a closing gcd check, then two restoring divisions of 2*OPERAND_BITS bits
// - binary gcd: every subtraction is followed by a shift and at most
//   4*OPERAND_BITS bits are shifted out, so at most 8*OPERAND_BITS steps
// - zero over zero skips both divisions; one transaction at a time
// - reset (synchronous, active high) returns the sequencer to idle and clears
//   the result strobe; no results are pending after reset

module rational_arith_reduce_unit #(
   parameter int OPERAND_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic signed [OPERAND_BITS-1:0]    req_left_num,
   input  logic signed [OPERAND_BITS-1:0]    req_left_den,
   input  logic signed [OPERAND_BITS-1:0]    req_right_num,
   input  logic signed [OPERAND_BITS-1:0]    req_right_den,
   output logic                              rsp_valid,
   output logic signed [rar_pkg::RESULT_BITS-1:0] rsp_result_num,
   output logic signed [rar_pkg::RESULT_BITS-1:0] rsp_result_den,
   output logic                              rsp_zero_den_error
);

   // magnitude width of products and sums
   localparam int MW = 2 * OPERAND_BITS;
   localparam int KW = $clog2(MW + 1);
   localparam int RW = rar_pkg::RESULT_BITS;
   localparam int XW = (MW > RW) ? MW : RW;

   // two's complement of a magnitude, reduced to the result width
   function automatic logic [RW-1:0] to_field(input logic neg, input logic [MW-1:0] mag);
      logic [XW-1:0] ext;
      begin
         ext = XW'(mag);
         if (neg) begin
            ext = ~ext + XW'(1);
         end
         to_field = ext[RW-1:0];
      end
   endfunction

   // operand sign and magnitude split
   function automatic logic [OPERAND_BITS-1:0] op_mag(input logic [OPERAND_BITS-1:0] raw);
      begin
         op_mag = raw[OPERAND_BITS-1] ? (~raw + OPERAND_BITS'(1)) : raw;
      end
   endfunction

   // sequencer state
   rar_pkg::state_type               state_ff, state_in;
   rar_pkg::mstep_type               step_ff, step_in;
   rar_pkg::action_type              act_ff, act_in;

   // operand magnitudes and signs
   logic [OPERAND_BITS-1:0]          ln_ff, ld_ff, rn_ff, rd_ff;
   logic [OPERAND_BITS-1:0]          ln_in, ld_in, rn_in, rd_in;
   logic                             lns_ff, lds_ff, rns_ff, rds_ff;
   logic                             lns_in, lds_in, rns_in, rds_in;

   // cross products and combined fraction
   logic [MW-1:0]                    t1_ff, t2_ff, t1_in, t2_in;
   logic                             t1s_ff, t2s_ff, t1s_in, t2s_in;
   logic [MW-1:0]                    n_ff, d_ff, n_in, d_in;
   logic                             ns_ff, ds_ff, ns_in, ds_in;

   // gcd and divider working registers
   logic [MW-1:0]                    a_ff, b_ff, a_in, b_in;
   logic [KW-1:0]                    k_ff, k_in;
   logic [MW-1:0]                    g_ff, g_in;
   logic [MW-1:0]                    rem_ff, rem_in;
   logic [MW-1:0]                    quo_ff, quo_in;
   logic [MW-1:0]                    qn_ff, qn_in;
   logic [KW-1:0]                    cnt_ff, cnt_in;

   // result registers
   logic                             vld_ff, vld_in;
   logic [RW-1:0]                    rnum_ff, rnum_in;
   logic [RW-1:0]                    rden_ff, rden_in;
   logic                             err_ff, err_in;

   // shared multiplier
   logic [OPERAND_BITS-1:0]          mul_x, mul_y;
   logic                             mul_sx, mul_sy;
   logic [MW-1:0]                    prod;
   logic                             prod_s;

   // shared compare/subtract unit
   logic [MW:0]                      sub_x, sub_y;
   logic [MW+1:0]                    sub_diff;
   logic                             sub_ge;

   // combine and divider helpers
   logic [MW-1:0]                    sum_mag;
   logic                             sum_s;
   logic [MW:0]                      rem_sh;
   logic [MW-1:0]                    rem_next;
   logic [MW-1:0]                    quo_next;
   logic                             t2s_eff;

   // multiplier operand select by step and action
   always_comb begin
      mul_x  = ln_ff;
      mul_sx = lns_ff;
      mul_y  = rd_ff;
      mul_sy = rds_ff;
      case (step_ff)
         rar_pkg::MSTEP_T1: begin
            mul_x  = ln_ff;
            mul_sx = lns_ff;
            if (act_ff == rar_pkg::ACT_MUL) begin
               mul_y  = rn_ff;
               mul_sy = rns_ff;
            end else begin
               mul_y  = rd_ff;
               mul_sy = rds_ff;
            end
         end
         rar_pkg::MSTEP_T2: begin
            mul_x  = ld_ff;
            mul_sx = lds_ff;
            mul_y  = rn_ff;
            mul_sy = rns_ff;
         end
         rar_pkg::MSTEP_DEN: begin
            mul_x  = ld_ff;
            mul_sx = lds_ff;
            if (act_ff == rar_pkg::ACT_DIV) begin
               mul_y  = rn_ff;
               mul_sy = rns_ff;
            end else begin
               mul_y  = rd_ff;
               mul_sy = rds_ff;
            end
         end
         default: begin
            mul_x  = ln_ff;
            mul_sx = lns_ff;
            mul_y  = rd_ff;
            mul_sy = rds_ff;
         end
      endcase
   end

   assign prod   = MW'(mul_x) * MW'(mul_y);
   assign prod_s = (prod != '0) && (mul_sx ^ mul_sy);

   // shared subtractor operands depend on the phase
   assign rem_sh = {rem_ff, quo_ff[MW-1]};

   always_comb begin
      case (state_ff)
         rar_pkg::ST_SUM: begin
            sub_x = {1'b0, t1_ff};
            sub_y = {1'b0, t2_ff};
         end
         rar_pkg::ST_GCD: begin
            sub_x = {1'b0, a_ff};
            sub_y = {1'b0, b_ff};
         end
         rar_pkg::ST_DIV_N, rar_pkg::ST_DIV_D: begin
            sub_x = rem_sh;
            sub_y = {1'b0, g_ff};
         end
         default: begin
            sub_x = {1'b0, a_ff};
            sub_y = {1'b0, b_ff};
         end
      endcase
   end

   assign sub_diff = {1'b0, sub_x} - {1'b0, sub_y};
   assign sub_ge   = ~sub_diff[MW+1];

   // subtract flips the sign of the second term
   assign t2s_eff = (act_ff == rar_pkg::ACT_SUB) ? ((t2_ff != '0) && !t2s_ff) : t2s_ff;

   // signed sum of the two numerator terms
   always_comb begin
      if (t1s_ff == t2s_eff) begin
         sum_mag = t1_ff + t2_ff;
         sum_s   = t1s_ff;
      end else if (sub_ge) begin
         sum_mag = sub_diff[MW-1:0];
         sum_s   = t1s_ff;
      end else begin
         sum_mag = ~sub_diff[MW-1:0] + MW'(1);
         sum_s   = t2s_eff;
      end
      if (sum_mag == '0) begin
         sum_s = 1'b0;
      end
   end

   // one restoring division step
   assign rem_next = sub_ge ? sub_diff[MW-1:0] : rem_sh[MW-1:0];
   assign quo_next = {quo_ff[MW-2:0], sub_ge};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rar_pkg::ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      act_ff  <= act_in;
      ln_ff   <= ln_in;
      ld_ff   <= ld_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      lns_ff  <= lns_in;
      lds_ff  <= lds_in;
      rns_ff  <= rns_in;
      rds_ff  <= rds_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      t1s_ff  <= t1s_in;
      t2s_ff  <= t2s_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      ns_ff   <= ns_in;
      ds_ff   <= ds_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      g_ff    <= g_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      qn_ff   <= qn_in;
      cnt_ff  <= cnt_in;
      rnum_ff <= rnum_in;
      rden_ff <= rden_in;
      err_ff  <= err_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      act_in   = act_ff;
      ln_in    = ln_ff;
      ld_in    = ld_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      lns_in   = lns_ff;
      lds_in   = lds_ff;
      rns_in   = rns_ff;
      rds_in   = rds_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      t1s_in   = t1s_ff;
      t2s_in   = t2s_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      ns_in    = ns_ff;
      ds_in    = ds_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      g_in     = g_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      qn_in    = qn_ff;
      cnt_in   = cnt_ff;
      vld_in   = 1'b0;
      rnum_in  = rnum_ff;
      rden_in  = rden_ff;
      err_in   = err_ff;

      case (state_ff)
         rar_pkg::ST_IDLE: begin
            if (start) begin
               act_in   = rar_pkg::action_type'(req_action);
               ln_in    = op_mag(req_left_num);
               ld_in    = op_mag(req_left_den);
               rn_in    = op_mag(req_right_num);
               rd_in    = op_mag(req_right_den);
               lns_in   = req_left_num[OPERAND_BITS-1];
               lds_in   = req_left_den[OPERAND_BITS-1];
               rns_in   = req_right_num[OPERAND_BITS-1];
               rds_in   = req_right_den[OPERAND_BITS-1];
               step_in  = rar_pkg::MSTEP_T1;
               state_in = rar_pkg::ST_MUL;
            end
         end

         rar_pkg::ST_MUL: begin
            case (step_ff)
               rar_pkg::MSTEP_T1: begin
                  t1_in   = prod;
                  t1s_in  = prod_s;
                  step_in = rar_pkg::MSTEP_T2;
               end
               rar_pkg::MSTEP_T2: begin
                  // only add and subtract use the second cross term
                  if (act_ff == rar_pkg::ACT_ADD || act_ff == rar_pkg::ACT_SUB) begin
                     t2_in  = prod;
                     t2s_in = prod_s;
                  end else begin
                     t2_in  = '0;
                     t2s_in = 1'b0;
                  end
                  step_in = rar_pkg::MSTEP_DEN;
               end
               default: begin
                  d_in     = prod;
                  ds_in    = prod_s;
                  state_in = rar_pkg::ST_SUM;
               end
            endcase
         end

         rar_pkg::ST_SUM: begin
            n_in     = sum_mag;
            ns_in    = sum_s;
            a_in     = sum_mag;
            b_in     = d_ff;
            k_in     = '0;
            state_in = rar_pkg::ST_GCD;
         end

         rar_pkg::ST_GCD: begin
            if (a_ff == '0 && b_ff == '0) begin
               // zero over zero
               rnum_in  = '0;
               rden_in  = '0;
               err_in   = 1'b1;
               vld_in   = 1'b1;
               state_in = rar_pkg::ST_IDLE;
            end else if (a_ff == '0 || b_ff == '0) begin
               g_in     = (a_ff | b_ff) << k_ff;
               rem_in   = '0;
               quo_in   = n_ff;
               cnt_in   = KW'(MW);
               state_in = rar_pkg::ST_DIV_N;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (sub_ge) begin
               a_in = sub_diff[MW-1:0];
            end else begin
               b_in = ~sub_diff[MW-1:0] + MW'(1);
            end
         end

         rar_pkg::ST_DIV_N: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - KW'(1);
            if (cnt_ff == KW'(1)) begin
               qn_in    = quo_next;
               rem_in   = '0;
               quo_in   = d_ff;
               cnt_in   = KW'(MW);
               state_in = rar_pkg::ST_DIV_D;
            end
         end

         rar_pkg::ST_DIV_D: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - KW'(1);
            if (cnt_ff == KW'(1)) begin
               rnum_in  = to_field(ns_ff, qn_ff);
               rden_in  = to_field(ds_ff, quo_next);
               err_in   = (d_ff == '0);
               vld_in   = 1'b1;
               state_in = rar_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rar_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != rar_pkg::ST_IDLE);
   assign rsp_valid          = vld_ff;
   assign rsp_result_num     = rnum_ff;
   assign rsp_result_den     = rden_ff;
   assign rsp_zero_den_error = err_ff;

   // a command taken makes the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted but unit not busy");

   // the result strobe comes with the return to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a zero denominator always reports a zero reduced denominator
   a_err_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_den_error) |-> (rsp_result_den == '0))
      else $error("error flag with nonzero denominator");

endmodule

// File: tb/sv/rational_arith_reduce_unit_test.sv
// rational_arith_reduce_unit_test: self-checking bench for the rational arithmetic reduce unit
// drives fraction transactions through start/busy and checks each reduced result in order
// depends on rar_pkg and rational_arith_reduce_unit

module rational_arith_reduce_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPERAND_BITS = 16;
   localparam int RESULT_BITS = rar_pkg::RESULT_BITS;
   // longer than the worst-case transaction, so this covers a late result
   localparam int DRAIN_CYCLES = 250;
   // ~1230 transactions at the worst-case busy time plus the longest sender gap, several times over
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_ITEMS = 1200;

   typedef logic signed [OPERAND_BITS-1:0] operand_type;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] num;
      logic signed [RESULT_BITS-1:0] den;
      logic                          zero_den;
   } fraction_type;

   // reduced fractions expected from the unit, oldest first
   class fraction_scoreboard;
      fraction_type expected_fractions[$];
      int unsigned  failures;

      function new();
         failures = 0;
      endfunction

      // cross-multiply, then divide both terms by gcd(|n|, |d|); signs stay as computed
      function fraction_type reduce_fraction(rar_pkg::action_type act, operand_type ln,
                                             operand_type ld, operand_type rn,
                                             operand_type rd);
         longint       ln_v, ld_v, rn_v, rd_v;
         longint       n, d, a, b, t;
         fraction_type r;
         ln_v = ln;
         ld_v = ld;
         rn_v = rn;
         rd_v = rd;
         case (act)
            rar_pkg::ACT_ADD: begin
               n = ln_v * rd_v + ld_v * rn_v;
               d = ld_v * rd_v;
            end
            rar_pkg::ACT_SUB: begin
               n = ln_v * rd_v - ld_v * rn_v;
               d = ld_v * rd_v;
            end
            rar_pkg::ACT_MUL: begin
               n = ln_v * rn_v;
               d = ld_v * rd_v;
            end
            default: begin
               n = ln_v * rd_v;
               d = ld_v * rn_v;
            end
         endcase
         a = (n < 0) ? -n : n;
         b = (d < 0) ? -d : d;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         if (a == 0) begin
            // zero over zero
            r.num      = '0;
            r.den      = '0;
            r.zero_den = 1'b1;
         end else begin
            r.num      = RESULT_BITS'(n / a);
            r.den      = RESULT_BITS'(d / a);
            r.zero_den = (d == 0);
         end
         return r;
      endfunction

      function void note_request(rar_pkg::action_type act, operand_type ln, operand_type ld,
                                 operand_type rn, operand_type rd);
         expected_fractions.push_back(reduce_fraction(act, ln, ld, rn, rd));
      endfunction

      function void check_result(fraction_type actual);
         fraction_type want;
         if (expected_fractions.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d/%0d err %0b",
                     $time, actual.num, actual.den, actual.zero_den);
            failures++;
            return;
         end
         want = expected_fractions.pop_front();
         if (actual.num !== want.num) begin
            $display("%0t: result_num mismatch, expected %0d, actual %0d",
                     $time, want.num, actual.num);
            failures++;
         end
         if (actual.den !== want.den) begin
            $display("%0t: result_den mismatch, expected %0d, actual %0d",
                     $time, want.den, actual.den);
            failures++;
         end
         if (actual.zero_den !== want.zero_den) begin
            $display("%0t: zero_den_error mismatch, expected %0b, actual %0b",
                     $time, want.zero_den, actual.zero_den);
            failures++;
         end
      endfunction

      function int pending();
         return expected_fractions.size();
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   rar_pkg::action_type req_action = rar_pkg::ACT_ADD;
   operand_type         req_left_num = '0;
   operand_type         req_left_den = '0;
   operand_type         req_right_num = '0;
   operand_type         req_right_den = '0;
   logic                rsp_valid;
   logic signed [RESULT_BITS-1:0] rsp_result_num;
   logic signed [RESULT_BITS-1:0] rsp_result_den;
   logic                rsp_zero_den_error;

   fraction_scoreboard sb;
   int unsigned        cycle_count = 0;
   int unsigned        quiet_left = 0;

   rational_arith_reduce_unit #(
      .OPERAND_BITS(OPERAND_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_left_num(req_left_num),
      .req_left_den(req_left_den),
      .req_right_num(req_right_num),
      .req_right_den(req_right_den),
      .rsp_valid(rsp_valid),
      .rsp_result_num(rsp_result_num),
      .rsp_result_den(rsp_result_den),
      .rsp_zero_den_error(rsp_zero_den_error)
   );

   // 20 ns period, first rising edge at 10 ns
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // hard stop in case the unit hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // monitor: samples pre-edge values, so the driver's nonblocking updates never race it
   // results are checked before the new transaction is noted, since busy drops with rsp_valid
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            sb.check_result({rsp_result_num, rsp_result_den, rsp_zero_den_error});
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_action, req_left_num, req_left_den, req_right_num,
                            req_right_den);
      end
   end

   // mix of full range, small values, zeros, extremes and values rich in common factors
   function automatic operand_type pick_operand();
      case ($urandom_range(9, 0))
         0, 1, 2, 3: return operand_type'($urandom);
         4, 5:       return operand_type'(int'($urandom_range(16, 0)) - 8);
         6:          return '0;
         7: begin
            case ($urandom_range(3, 0))
               0:       return operand_type'(-32768);
               1:       return operand_type'(32767);
               2:       return operand_type'(-1);
               default: return operand_type'(1);
            endcase
         end
         8:          return operand_type'((1 << $urandom_range(14, 0)) *
                                          ($urandom_range(1, 0) ? -1 : 1));
         default:    return operand_type'(int'($urandom_range(180, 0)) *
                                          (int'($urandom_range(12, 0)) - 6));
      endcase
   endfunction

   // optional idle gap with junk on the request fields, then one transaction held until taken
   task automatic send_request(input int unsigned gap, input rar_pkg::action_type act,
                               input operand_type ln, input operand_type ld,
                               input operand_type rn, input operand_type rd);
      if (gap != 0) begin
         start <= 1'b0;
         for (int unsigned i = 0; i < gap; i++) begin
            req_action    <= rar_pkg::action_type'($urandom_range(3, 0));
            req_left_num  <= operand_type'($urandom);
            req_left_den  <= operand_type'($urandom);
            req_right_num <= operand_type'($urandom);
            req_right_den <= operand_type'($urandom);
            @(posedge clock);
         end
      end
      start         <= 1'b1;
      req_action    <= act;
      req_left_num  <= ln;
      req_left_den  <= ld;
      req_right_num <= rn;
      req_right_den <= rd;
      // accepted at the first edge with busy low
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   // sender holds off until every outstanding transaction has returned
   task automatic hold_until_drained();
      start <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   initial begin
      int unsigned gap;
      int unsigned roll;

      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every action, operand extremes, zero denominators, zero over zero,
      // zero numerators and negative denominators
      send_request(0, rar_pkg::ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      send_request(1, rar_pkg::ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
      send_request(0, rar_pkg::ACT_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4);
      send_request(2, rar_pkg::ACT_DIV, 16'sd2, 16'sd3, 16'sd4, 16'sd9);
      send_request(0, rar_pkg::ACT_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
      send_request(0, rar_pkg::ACT_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd7);
      send_request(3, rar_pkg::ACT_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);
      send_request(0, rar_pkg::ACT_MUL, -16'sd5, 16'sd0, 16'sd3, 16'sd2);
      send_request(0, rar_pkg::ACT_MUL, 16'sd0, 16'sd7, 16'sd3, 16'sd5);
      send_request(1, rar_pkg::ACT_MUL, 16'sd0, -16'sd7, 16'sd3, 16'sd5);
      send_request(0, rar_pkg::ACT_ADD, 16'sd1, -16'sd2, 16'sd1, 16'sd3);
      send_request(0, rar_pkg::ACT_MUL, operand_type'(-32768), operand_type'(-32768),
                   operand_type'(-32768), operand_type'(-32768));
      send_request(0, rar_pkg::ACT_ADD, operand_type'(-32768), 16'sd1,
                   operand_type'(-32768), 16'sd1);
      send_request(0, rar_pkg::ACT_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1);
      send_request(0, rar_pkg::ACT_MUL, operand_type'(-32768), 16'sd1,
                   operand_type'(-32768), 16'sd1);
      send_request(2, rar_pkg::ACT_ADD, operand_type'(-32768), 16'sd32767,
                   operand_type'(-32768), 16'sd32767);
      send_request(0, rar_pkg::ACT_SUB, operand_type'(-32768), 16'sd32767, 16'sd32767,
                   operand_type'(-32768));
      send_request(0, rar_pkg::ACT_DIV, 16'sd32767, operand_type'(-32768),
                   operand_type'(-32768), 16'sd32767);
      send_request(0, rar_pkg::ACT_ADD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_request(0, rar_pkg::ACT_DIV, 16'sd1, 16'sd1, -16'sd1, 16'sd1);
      send_request(1, rar_pkg::ACT_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_request(0, rar_pkg::ACT_DIV, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
      send_request(0, rar_pkg::ACT_MUL, operand_type'(-32768), 16'sd32767,
                   operand_type'(-32768), 16'sd32767);
      send_request(0, rar_pkg::ACT_SUB, 16'sd0, operand_type'(-32768), 16'sd0, 16'sd32767);

      // let everything come back before the random part
      hold_until_drained();

      // random: mostly short gaps, some longer, a few long ones and back-to-back bursts
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            hold_until_drained();
            gap = 0;
         end else if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
         end else begin
            roll = $urandom_range(99, 0);
            if (roll < 3)
               quiet_left = $urandom_range(40, 10);
            if (roll < 70)
               gap = $urandom_range(2, 0);
            else if (roll < 95)
               gap = $urandom_range(12, 3);
            else
               gap = $urandom_range(120, 20);
         end
         send_request(gap, rar_pkg::action_type'($urandom_range(3, 0)), pick_operand(),
                      pick_operand(), pick_operand(), pick_operand());
      end

      // wait for the last results, then watch for strays
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
